// File: src/sqc_pkg.sv
`default_nettype none
package sqc_pkg;

  // pipeline depth of the two long dividers
  localparam int DEPTH_STEPS = 40;
  localparam int TEX_STEPS   = 18;
  localparam int NUM_VERTS   = 6;

  // configuration register indexes
  localparam logic [2:0] REG_VIEW_WIDTH    = 3'd0;
  localparam logic [2:0] REG_VIEW_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_NEAR_SCREEN   = 3'd2;
  localparam logic [2:0] REG_FAR_SCREEN    = 3'd3;
  localparam logic [2:0] REG_NEAR_CLIP     = 3'd4;
  localparam logic [2:0] REG_FAR_CLIP      = 3'd5;

  localparam logic [14:0] RST_VIEW_WIDTH    = 15'd10240;
  localparam logic [14:0] RST_VIEW_HEIGHT   = 15'd7680;
  localparam logic [31:0] RST_NEAR_SCREEN   = 32'd0;
  localparam logic [31:0] RST_FAR_SCREEN    = 32'd65536;
  localparam logic [31:0] RST_NEAR_CLIP     = 32'd16384;
  localparam logic [31:0] RST_FAR_CLIP      = 32'd131072000;

  // axis slots: low and high edge of x and y
  localparam logic [1:0] AX_XLO = 2'd0;
  localparam logic [1:0] AX_XHI = 2'd1;
  localparam logic [1:0] AX_YLO = 2'd2;
  localparam logic [1:0] AX_YHI = 2'd3;

  localparam logic [2:0] LAST_VERT = 3'(NUM_VERTS - 1);

  localparam logic signed [17:0] TEX_MAX = 18'sd131071;
  localparam logic signed [17:0] TEX_MIN = -18'sd131072;
  localparam logic signed [17:0] TEX_ONE = 18'sd65536;
  localparam logic [17:0] RIGHT_Q_MAX = 18'd196608;

  typedef enum logic [1:0] {
    SIDE_NONE,
    SIDE_LEFT,
    SIDE_RIGHT
  } side_t;

  // one clamped coordinate with its texture divider state
  typedef struct packed {
    logic [14:0] coord;
    side_t       side;
    logic        hi;
    logic [15:0] den;
    logic        sat;
    logic [15:0] rem;
    logic [17:0] nb;
    logic [17:0] q;
  } axis_t;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] rz;
    logic [7:0]  alpha;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pass_t;

  typedef struct packed {
    pass_t       pass;
    axis_t [3:0] ax;
    logic        neg;
    logic        mz;
    logic        nz;
    logic        dsat;
    logic [63:0] drem;
    logic [63:0] m;
    logic [39:0] dq;
    logic [39:0] nlow;
  } item_t;

  function automatic logic [7:0] scale_color(input logic [7:0] c, input logic [8:0] k);
    logic [16:0] p;
    begin
      p = 17'(c) * 17'(k);
      scale_color = (p[16:8] > 9'd255) ? 8'd255 : p[15:8];
    end
  endfunction

  // classify against the screen edges and set up the texture divide
  function automatic axis_t axis_setup(input logic signed [16:0] c, input logic [14:0] half,
                                       input logic [14:0] lim, input logic hi);
    axis_t a;
    logic [16:0] dv;
    logic signed [16:0] slim;
    begin
      slim = $signed({2'b00, lim});
      a.hi = hi;
      if (c < 0) begin
        a.side = SIDE_LEFT;
        a.coord = '0;
        dv = 17'(-c);
      end else if (c > slim) begin
        a.side = SIDE_RIGHT;
        a.coord = lim;
        dv = 17'(c - slim);
      end else begin
        a.side = SIDE_NONE;
        a.coord = c[14:0];
        dv = '0;
      end
      a.den = {half, 1'b0};
      a.sat = ({1'b0, dv[16:2]} >= a.den);
      a.rem = {1'b0, dv[16:2]};
      a.nb = {dv[1:0], 16'd0};
      a.q = '0;
      axis_setup = a;
    end
  endfunction

  // one restoring step of the texture divide
  function automatic axis_t tex_step(input axis_t a);
    axis_t r;
    logic [16:0] r2;
    begin
      r = a;
      r2 = {a.rem, a.nb[17]};
      if (r2 >= {1'b0, a.den}) begin
        r.rem = 16'(r2 - {1'b0, a.den});
        r.q = {a.q[16:0], 1'b1};
      end else begin
        r.rem = r2[15:0];
        r.q = {a.q[16:0], 1'b0};
      end
      r.nb = {a.nb[16:0], 1'b0};
      tex_step = r;
    end
  endfunction

  function automatic logic signed [17:0] tex_final(input axis_t a);
    logic signed [18:0] t;
    logic zero_den;
    begin
      zero_den = (a.den == '0);
      t = 19'sd65536 - $signed({1'b0, a.q});
      unique case (a.side)
        SIDE_LEFT: begin
          if (zero_den || a.sat || a.q[17]) tex_final = TEX_MAX;
          else tex_final = $signed(a.q);
        end
        SIDE_RIGHT: begin
          if (zero_den || a.sat || a.q > RIGHT_Q_MAX) tex_final = TEX_MIN;
          else tex_final = t[17:0];
        end
        default: tex_final = a.hi ? TEX_ONE : 18'sd0;
      endcase
    end
  endfunction

  // one restoring step of the depth divide, plus a texture step where asked
  function automatic item_t item_step(input item_t it, input logic do_tex);
    item_t r;
    logic [64:0] r2;
    begin
      r = it;
      r2 = {it.drem, it.nlow[39]};
      if (r2 >= {1'b0, it.m}) begin
        r.drem = 64'(r2 - {1'b0, it.m});
        r.dq = {it.dq[38:0], 1'b1};
      end else begin
        r.drem = r2[63:0];
        r.dq = {it.dq[38:0], 1'b0};
      end
      r.nlow = {it.nlow[38:0], 1'b0};
      if (do_tex) begin
        for (int i = 0; i < 4; i++) r.ax[i] = tex_step(it.ax[i]);
      end
      item_step = r;
    end
  endfunction

  // corner order 0,1,2,3,0,2
  function automatic logic [1:0] corner_of(input logic [2:0] n);
    begin
      unique case (n)
        3'd0: corner_of = 2'd0;
        3'd1: corner_of = 2'd1;
        3'd2: corner_of = 2'd2;
        3'd3: corner_of = 2'd3;
        3'd4: corner_of = 2'd0;
        3'd5: corner_of = 2'd2;
        default: corner_of = 2'd0;
      endcase
    end
  endfunction

endpackage
`default_nettype wire

// File: src/sqc_if.sv
`default_nettype none
// sprite word channel
interface sqc_sprite_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] centre_x;
  logic signed [15:0] centre_y;
  logic [31:0]        depth;
  logic [14:0]        half_width;
  logic [14:0]        half_height;
  logic [7:0]         red_in;
  logic [7:0]         green_in;
  logic [7:0]         blue_in;
  logic [8:0]         intensity;
  logic [31:0]        recip_depth_in;
  logic [7:0]         alpha_in;
  modport source (output valid, centre_x, centre_y, depth, half_width, half_height,
                  red_in, green_in, blue_in, intensity, recip_depth_in, alpha_in,
                  input ready);
  modport sink (input valid, centre_x, centre_y, depth, half_width, half_height,
                red_in, green_in, blue_in, intensity, recip_depth_in, alpha_in,
                output ready);
endinterface

// vertex word channel
interface sqc_vertex_if;
  logic               valid;
  logic               ready;
  logic [14:0]        vert_x;
  logic [14:0]        vert_y;
  logic [31:0]        screen_depth;
  logic [31:0]        camera_depth;
  logic [31:0]        recip_depth_out;
  logic [7:0]         red_out;
  logic [7:0]         green_out;
  logic [7:0]         blue_out;
  logic [7:0]         alpha_out;
  logic signed [17:0] tex_u;
  logic signed [17:0] tex_v;
  logic               last_vertex;
  modport source (output valid, vert_x, vert_y, screen_depth, camera_depth,
                  recip_depth_out, red_out, green_out, blue_out, alpha_out, tex_u, tex_v,
                  last_vertex, input ready);
  modport sink (input valid, vert_x, vert_y, screen_depth, camera_depth,
                recip_depth_out, red_out, green_out, blue_out, alpha_out, tex_u, tex_v,
                last_vertex, output ready);
endinterface
`default_nettype wire

// File: src/sprite_quad_clip_setup_unit.sv
// first vertex word: stages 1 to 4, divider entry, divider steps, vertex output register,
//   then one a cycle while the port is ready
// sprite rate: set by the six vertex words of each sprite on the output port;
//   the 40 step depth divider and 18 step texture dividers are fully pipelined
// reset: synchronous, clears all valid bits and loads the register defaults
`default_nettype none
module sprite_quad_clip_setup_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  sqc_sprite_if.sink       sprite,
  sqc_vertex_if.source     vertex,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int NS = sqc_pkg::DEPTH_STEPS;

  logic [14:0] view_width;
  logic [14:0] view_height;
  logic [31:0] near_screen;
  logic [31:0] far_screen;
  logic [31:0] near_clip;
  logic [31:0] far_clip;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      view_width    <= sqc_pkg::RST_VIEW_WIDTH;
      view_height   <= sqc_pkg::RST_VIEW_HEIGHT;
      near_screen   <= sqc_pkg::RST_NEAR_SCREEN;
      far_screen    <= sqc_pkg::RST_FAR_SCREEN;
      near_clip     <= sqc_pkg::RST_NEAR_CLIP;
      far_clip      <= sqc_pkg::RST_FAR_CLIP;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sqc_pkg::REG_VIEW_WIDTH:    view_width    <= cfg_data[14:0];
        sqc_pkg::REG_VIEW_HEIGHT:   view_height   <= cfg_data[14:0];
        sqc_pkg::REG_NEAR_SCREEN:   near_screen   <= cfg_data;
        sqc_pkg::REG_FAR_SCREEN:    far_screen    <= cfg_data;
        sqc_pkg::REG_NEAR_CLIP:     near_clip     <= cfg_data;
        sqc_pkg::REG_FAR_CLIP:      far_clip      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  logic load_emit;

  // stage 1: corners, colour scale, depth differences
  logic                      v1;
  logic signed [16:0]        s1_c [4];
  logic [14:0]               s1_hw;
  logic [14:0]               s1_hh;
  logic [31:0]               s1_a;
  logic [31:0]               s1_e;
  logic [31:0]               s1_d;
  logic                      s1_neg;
  sqc_pkg::pass_t            s1_pass;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= sprite.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_c[sqc_pkg::AX_XLO] <= 17'({sprite.centre_x[15], sprite.centre_x} -
                                   {2'b00, sprite.half_width});
      s1_c[sqc_pkg::AX_XHI] <= 17'({sprite.centre_x[15], sprite.centre_x} +
                                   {2'b00, sprite.half_width});
      s1_c[sqc_pkg::AX_YLO] <= 17'({sprite.centre_y[15], sprite.centre_y} -
                                   {2'b00, sprite.half_height});
      s1_c[sqc_pkg::AX_YHI] <= 17'({sprite.centre_y[15], sprite.centre_y} +
                                   {2'b00, sprite.half_height});
      s1_hw <= sprite.half_width;
      s1_hh <= sprite.half_height;
      s1_a <= (sprite.depth < near_clip) ? near_clip - sprite.depth : sprite.depth - near_clip;
      s1_e <= (far_screen < near_screen) ? near_screen - far_screen : far_screen - near_screen;
      s1_d <= (far_clip < near_clip) ? near_clip - far_clip : far_clip - near_clip;
      s1_neg <= (sprite.depth < near_clip) ^ (far_screen < near_screen) ^
                (far_clip < near_clip);
      s1_pass.z     <= sprite.depth;
      s1_pass.rz    <= sprite.recip_depth_in;
      s1_pass.alpha <= sprite.alpha_in;
      s1_pass.red   <= sqc_pkg::scale_color(sprite.red_in, sprite.intensity);
      s1_pass.green <= sqc_pkg::scale_color(sprite.green_in, sprite.intensity);
      s1_pass.blue  <= sqc_pkg::scale_color(sprite.blue_in, sprite.intensity);
    end
  end

  // stage 2: depth products, edge clamps and texture divide setup
  logic                     v2;
  sqc_pkg::axis_t [3:0]     s2_ax;
  logic [63:0]              s2_n;
  logic [63:0]              s2_m;
  logic [31:0]              s2_e;
  logic                     s2_neg;
  sqc_pkg::pass_t           s2_pass;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ax[sqc_pkg::AX_XLO] <= sqc_pkg::axis_setup(s1_c[sqc_pkg::AX_XLO], s1_hw,
                                                    view_width, 1'b0);
      s2_ax[sqc_pkg::AX_XHI] <= sqc_pkg::axis_setup(s1_c[sqc_pkg::AX_XHI], s1_hw,
                                                    view_width, 1'b1);
      s2_ax[sqc_pkg::AX_YLO] <= sqc_pkg::axis_setup(s1_c[sqc_pkg::AX_YLO], s1_hh,
                                                    view_height, 1'b0);
      s2_ax[sqc_pkg::AX_YHI] <= sqc_pkg::axis_setup(s1_c[sqc_pkg::AX_YHI], s1_hh,
                                                    view_height, 1'b1);
      s2_n <= 64'(s1_a) * 64'(far_clip);
      s2_m <= 64'(s1_d) * 64'(s1_pass.z);
      s2_e <= s1_e;
      s2_neg <= s1_neg;
      s2_pass <= s1_pass;
    end
  end

  // stage 3: split 64 by 32 product into two partial products
  logic                     v3;
  sqc_pkg::axis_t [3:0]     s3_ax;
  logic [63:0]              s3_p0;
  logic [63:0]              s3_p1;
  logic [63:0]              s3_m;
  logic                     s3_neg;
  sqc_pkg::pass_t           s3_pass;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ax <= s2_ax;
      s3_p0 <= 64'(s2_n[31:0]) * 64'(s2_e);
      s3_p1 <= 64'(s2_n[63:32]) * 64'(s2_e);
      s3_m <= s2_m;
      s3_neg <= s2_neg;
      s3_pass <= s2_pass;
    end
  end

  // stage 4: sum partial products into the 96 bit dividend
  logic                     v4;
  sqc_pkg::axis_t [3:0]     s4_ax;
  logic [95:0]              s4_nn;
  logic [63:0]              s4_m;
  logic                     s4_neg;
  sqc_pkg::pass_t           s4_pass;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ax <= s3_ax;
      s4_nn <= {32'd0, s3_p0} + {s3_p1, 32'd0};
      s4_m <= s3_m;
      s4_neg <= s3_neg;
      s4_pass <= s3_pass;
    end
  end

  // divider stages: entry, then one quotient bit per stage
  sqc_pkg::item_t stg [NS+1];
  logic [NS:0]    stv;

  always_ff @(posedge clk) begin
    if (rst) stv <= '0;
    else if (adv) stv <= {stv[NS-1:0], v4};
  end

  // quotient of 2^40 or more saturates, checked up front
  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0].pass <= s4_pass;
      stg[0].ax   <= s4_ax;
      stg[0].neg  <= s4_neg;
      stg[0].mz   <= (s4_m == '0);
      stg[0].nz   <= (s4_nn == '0);
      stg[0].dsat <= ({8'd0, s4_nn[95:40]} >= s4_m);
      stg[0].drem <= {8'd0, s4_nn[95:40]};
      stg[0].m    <= s4_m;
      stg[0].dq   <= '0;
      stg[0].nlow <= s4_nn[39:0];
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) stg[k+1] <= sqc_pkg::item_step(stg[k], 1'(k < sqc_pkg::TEX_STEPS));
    end
  end

  // final depth mapping and texture saturation
  sqc_pkg::item_t  fin;
  logic [31:0]     fin_sd;
  logic [40:0]     fin_sum;

  always_comb begin
    fin = stg[NS];
    fin_sum = {1'b0, fin.dq} + 41'(near_screen);
    if (fin.mz) begin
      if (fin.nz) fin_sd = near_screen;
      else fin_sd = fin.neg ? 32'd0 : 32'hFFFF_FFFF;
    end else if (fin.neg) begin
      if (fin.dsat || fin.dq >= 40'(near_screen)) fin_sd = 32'd0;
      else fin_sd = near_screen - fin.dq[31:0];
    end else begin
      if (fin.dsat || fin_sum[40:32] != '0) fin_sd = 32'hFFFF_FFFF;
      else fin_sd = fin_sum[31:0];
    end
  end

  // vertex output register: holds one sprite and steps through its six vertex words
  logic                    em_valid;
  logic [2:0]              em_cnt;
  logic [14:0]             em_coord [4];
  logic signed [17:0]      em_tex [4];
  logic [31:0]             em_sd;
  sqc_pkg::pass_t          em_pass;
  logic                    em_last;

  assign em_last   = (em_cnt == sqc_pkg::LAST_VERT);
  assign load_emit = stv[NS] && (!em_valid || (em_last && vertex.ready));
  assign adv       = !stv[NS] || load_emit;
  assign sprite.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      em_valid <= 1'b0;
      em_cnt <= '0;
    end else if (load_emit) begin
      em_valid <= 1'b1;
      em_cnt <= '0;
    end else if (em_valid && vertex.ready) begin
      if (em_last) em_valid <= 1'b0;
      else em_cnt <= em_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_emit) begin
      for (int i = 0; i < 4; i++) begin
        em_coord[i] <= fin.ax[i].coord;
        em_tex[i] <= sqc_pkg::tex_final(fin.ax[i]);
      end
      em_sd <= fin_sd;
      em_pass <= fin.pass;
    end
  end

  // corner select for the current vertex word
  logic [1:0] corner;
  logic [1:0] xi;
  logic [1:0] yi;

  always_comb begin
    corner = sqc_pkg::corner_of(em_cnt);
    xi = corner[1] ? sqc_pkg::AX_XHI : sqc_pkg::AX_XLO;
    yi = (corner[0] ^ corner[1]) ? sqc_pkg::AX_YHI : sqc_pkg::AX_YLO;
  end

  assign vertex.valid           = em_valid;
  assign vertex.vert_x          = em_coord[xi];
  assign vertex.vert_y          = em_coord[yi];
  assign vertex.tex_u           = em_tex[xi];
  assign vertex.tex_v           = em_tex[yi];
  assign vertex.screen_depth    = em_sd;
  assign vertex.camera_depth    = em_pass.z;
  assign vertex.recip_depth_out = em_pass.rz;
  assign vertex.red_out         = em_pass.red;
  assign vertex.green_out       = em_pass.green;
  assign vertex.blue_out        = em_pass.blue;
  assign vertex.alpha_out       = em_pass.alpha;
  assign vertex.last_vertex     = em_last;

endmodule
`default_nettype wire

// File: tb/sqc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sqc_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  sqc_sprite_if            sprite,
  sqc_vertex_if            vertex,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               fails,
  output int               pending
);

  typedef struct packed {
    logic [14:0]        x;
    logic [14:0]        y;
    logic [31:0]        sdepth;
    logic [31:0]        cdepth;
    logic [31:0]        rdepth;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic signed [17:0] u;
    logic signed [17:0] v;
    logic               last;
  } vert_t;

  vert_t vert_q[$];

  // own copy of the register file
  logic [14:0] scr_w, scr_h;
  logic [31:0] near_scr, far_scr, near_clip, far_clip;

  assign pending = vert_q.size();

  function automatic longint tex_sat(input longint t);
    if (t > 131071) return 131071;
    if (t < -131072) return -131072;
    return t;
  endfunction

  // clamp one coordinate to [0, lim] and shift its texture coordinate
  function automatic void clip_axis(inout longint c, inout longint t,
                                    input longint half, input longint lim);
    longint den;
    den = 2 * half;
    if (c < 0) begin
      t = (den == 0) ? 131071 : tex_sat(((-c) << 16) / den);
      c = 0;
    end
    if (c > lim) begin
      t = (den == 0) ? -131072 : tex_sat(65536 - (((c - lim) << 16) / den));
      c = lim;
    end
  endfunction

  // camera depth to depth buffer value through the near/far planes
  function automatic logic [31:0] depth_map(input logic [31:0] z);
    logic [127:0] a, e, d, num, den, q;
    logic neg;
    a = (z >= near_clip) ? 128'(z - near_clip) : 128'(near_clip - z);
    e = (far_scr >= near_scr) ? 128'(far_scr - near_scr) : 128'(near_scr - far_scr);
    d = (far_clip >= near_clip) ? 128'(far_clip - near_clip) : 128'(near_clip - far_clip);
    neg = (z < near_clip) ^ (far_scr < near_scr) ^ (far_clip < near_clip);
    num = a * 128'(far_clip) * e;
    den = d * 128'(z);
    if (den == 0) begin
      if (num == 0) return near_scr;
      return neg ? 32'd0 : 32'hFFFF_FFFF;
    end
    q = num / den;
    if (neg) return (q >= 128'(near_scr)) ? 32'd0 : 32'(128'(near_scr) - q);
    if (q >= (128'd1 << 40)) return 32'hFFFF_FFFF;
    q = q + 128'(near_scr);
    return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic [7:0] tint(input logic [7:0] c, input logic [8:0] k);
    logic [16:0] p;
    p = 17'(c) * 17'(k);
    return (p[16:8] > 9'd255) ? 8'd255 : p[15:8];
  endfunction

  // six vertex words per sprite word, corners 0,1,2,3,0,2
  task automatic predict_quad();
    longint xs[4], ys[4], us[4], vs[4];
    longint cx, cy, hw, hh;
    int order[6];
    vert_t w;
    order = '{0, 1, 2, 3, 0, 2};
    cx = longint'(sprite.centre_x);
    cy = longint'(sprite.centre_y);
    hw = longint'(sprite.half_width);
    hh = longint'(sprite.half_height);
    xs = '{cx - hw, cx - hw, cx + hw, cx + hw};
    ys = '{cy - hh, cy + hh, cy + hh, cy - hh};
    us = '{0, 0, 65536, 65536};
    vs = '{0, 65536, 65536, 0};
    for (int i = 0; i < 4; i++) begin
      clip_axis(xs[i], us[i], hw, longint'(scr_w));
      clip_axis(ys[i], vs[i], hh, longint'(scr_h));
    end
    w.sdepth = depth_map(sprite.depth);
    w.cdepth = sprite.depth;
    w.rdepth = sprite.recip_depth_in;
    w.red    = tint(sprite.red_in, sprite.intensity);
    w.green  = tint(sprite.green_in, sprite.intensity);
    w.blue   = tint(sprite.blue_in, sprite.intensity);
    w.alpha  = sprite.alpha_in;
    for (int i = 0; i < sqc_pkg::NUM_VERTS; i++) begin
      w.x = xs[order[i]][14:0];
      w.y = ys[order[i]][14:0];
      w.u = us[order[i]][17:0];
      w.v = vs[order[i]][17:0];
      w.last = (i == sqc_pkg::NUM_VERTS - 1);
      vert_q.push_back(w);
    end
  endtask

  task automatic field_chk(input string nm, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= 10)
        $display("%0t vertex %s mismatch: expected %h got %h", $realtime, nm, want, got);
    end
  endtask

  always @(posedge clk) begin
    vert_t want;
    if (rst) begin
      scr_w     <= sqc_pkg::RST_VIEW_WIDTH;
      scr_h     <= sqc_pkg::RST_VIEW_HEIGHT;
      near_scr  <= sqc_pkg::RST_NEAR_SCREEN;
      far_scr   <= sqc_pkg::RST_FAR_SCREEN;
      near_clip <= sqc_pkg::RST_NEAR_CLIP;
      far_clip  <= sqc_pkg::RST_FAR_CLIP;
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          sqc_pkg::REG_VIEW_WIDTH:  scr_w     <= cfg_data[14:0];
          sqc_pkg::REG_VIEW_HEIGHT: scr_h     <= cfg_data[14:0];
          sqc_pkg::REG_NEAR_SCREEN: near_scr  <= cfg_data;
          sqc_pkg::REG_FAR_SCREEN:  far_scr   <= cfg_data;
          sqc_pkg::REG_NEAR_CLIP:   near_clip <= cfg_data;
          sqc_pkg::REG_FAR_CLIP:    far_clip  <= cfg_data;
          default: ;
        endcase
      end
      // sprite word taken
      if (sprite.valid && sprite.ready) predict_quad();
      // vertex word out
      if (vertex.valid && vertex.ready) begin
        if (vert_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%0t vertex word with nothing expected", $realtime);
        end else begin
          want = vert_q.pop_front();
          field_chk("vert_x", 32'(want.x), 32'(vertex.vert_x));
          field_chk("vert_y", 32'(want.y), 32'(vertex.vert_y));
          field_chk("screen_depth", want.sdepth, vertex.screen_depth);
          field_chk("camera_depth", want.cdepth, vertex.camera_depth);
          field_chk("recip_depth_out", want.rdepth, vertex.recip_depth_out);
          field_chk("red_out", 32'(want.red), 32'(vertex.red_out));
          field_chk("green_out", 32'(want.green), 32'(vertex.green_out));
          field_chk("blue_out", 32'(want.blue), 32'(vertex.blue_out));
          field_chk("alpha_out", 32'(want.alpha), 32'(vertex.alpha_out));
          field_chk("tex_u", 32'(unsigned'(want.u)), 32'(unsigned'(vertex.tex_u)));
          field_chk("tex_v", 32'(unsigned'(want.v)), 32'(unsigned'(vertex.tex_v)));
          field_chk("last_vertex", 32'(want.last), 32'(vertex.last_vertex));
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int SETTLE = 80;
  localparam int LIMIT  = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fails, pending, cycles = 0;
  int          rx_wait = 0, hold_left = 0;
  bit          hold_go = 1'b0, hold_done = 1'b0;

  sqc_sprite_if sprite ();
  sqc_vertex_if vertex ();

  sprite_quad_clip_setup_unit i_dut (
    .clk, .rst, .sprite, .vertex, .cfg_wr_en, .cfg_index, .cfg_data
  );

  sqc_checker i_chk (
    .clk, .rst, .sprite, .vertex, .cfg_wr_en, .cfg_index, .cfg_data, .fails, .pending
  );

  always #4 clk = ~clk;

  initial begin
    sprite.valid = 1'b0;
    sprite.centre_x = '0; sprite.centre_y = '0; sprite.depth = '0;
    sprite.half_width = '0; sprite.half_height = '0;
    sprite.red_in = '0; sprite.green_in = '0; sprite.blue_in = '0;
    sprite.intensity = '0; sprite.recip_depth_in = '0; sprite.alpha_in = '0;
    vertex.ready = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // vertex receiver: random stalls per word, plus one long hold-off
  always @(posedge clk) begin
    logic nxt;
    if (rst) begin
      vertex.ready <= 1'b0;
    end else begin
      if (vertex.valid && vertex.ready)
        rx_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        nxt = 1'b0;
      end else begin
        nxt = 1'b1;
      end
      vertex.ready <= nxt;
    end
  end

  // one register write, then waits with the write enable low
  task automatic wr_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // offer one sprite word after a random gap, return at the edge that takes it
  task automatic send_sprite(input logic [15:0] cx, input logic [15:0] cy,
                             input logic [31:0] z, input logic [14:0] hw,
                             input logic [14:0] hh, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b,
                             input logic [8:0] k, input logic [31:0] rz,
                             input logic [7:0] a);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      sprite.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sprite.valid <= 1'b1;
    sprite.centre_x <= cx; sprite.centre_y <= cy; sprite.depth <= z;
    sprite.half_width <= hw; sprite.half_height <= hh;
    sprite.red_in <= r; sprite.green_in <= g; sprite.blue_in <= b;
    sprite.intensity <= k; sprite.recip_depth_in <= rz; sprite.alpha_in <= a;
    forever begin
      @(negedge clk);
      if (sprite.ready) break;
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  // mostly sprites around the screen, some anywhere in the field ranges
  task automatic random_sprites(input int n);
    logic [15:0] cx, cy;
    logic [14:0] hw, hh;
    logic [31:0] z;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        cx = 16'($urandom_range(0, 12000)) - 16'd1000;
        cy = 16'($urandom_range(0, 9000)) - 16'd1000;
        hw = 15'($urandom_range(0, 2000));
        hh = 15'($urandom_range(0, 2000));
      end else begin
        cx = 16'($urandom); cy = 16'($urandom);
        hw = 15'($urandom); hh = 15'($urandom);
      end
      case ($urandom_range(0, 3))
        0: z = $urandom;
        1: z = 32'($urandom_range(0, 65536 * 200));
        2: z = 32'($urandom_range(0, 65536));
        default: z = (32'd1 << $urandom_range(0, 31)) + 32'($urandom_range(0, 3));
      endcase
      send_sprite(cx, cy, z, hw, hh, 8'($urandom), 8'($urandom), 8'($urandom),
                  ($urandom_range(0, 1) == 1) ? 9'($urandom_range(0, 256)) : 9'($urandom),
                  $urandom, 8'($urandom));
    end
  endtask

  // quiet point for register writes
  task automatic drain();
    sprite.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: edges of every field, zero sizes, depth corner cases
    send_sprite(16'd0, 16'd0, 32'd0, 15'd0, 15'd0, 8'd0, 8'd0, 8'd0, 9'd0, 32'd0, 8'd0);
    send_sprite(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 15'h7FFF, 15'h7FFF,
                8'd255, 8'd255, 8'd255, 9'h1FF, 32'hFFFF_FFFF, 8'd255);
    send_sprite(16'h8000, 16'h8000, 32'd16384, 15'h7FFF, 15'h7FFF,
                8'd255, 8'd128, 8'd1, 9'd256, 32'h0100_0000, 8'd128);
    send_sprite(16'h7FFF, 16'h7FFF, 32'd65536, 15'd0, 15'd0,
                8'd200, 8'd100, 8'd50, 9'd255, 32'h1234_5678, 8'd7);
    send_sprite(16'hFF00, 16'hFF00, 32'd1, 15'd0, 15'd0,
                8'd10, 8'd20, 8'd30, 9'd257, 32'd1, 8'd1);
    send_sprite(16'd5120, 16'd3840, 32'd655360, 15'd6000, 15'd5000,
                8'd255, 8'd255, 8'd255, 9'd256, 32'h00AA_AAAA, 8'd255);
    send_sprite(16'd5120, 16'd3840, 32'd131072000, 15'd100, 15'd100,
                8'd64, 8'd64, 8'd64, 9'd128, 32'd2, 8'd64);
    send_sprite(16'd100, 16'd100, 32'd8192, 15'd300, 15'd1,
                8'd1, 8'd2, 8'd3, 9'd300, 32'd3, 8'd3);
    send_sprite(16'd10300, 16'd7700, 32'd20000, 15'd1, 15'd50,
                8'd90, 8'd80, 8'd70, 9'd384, 32'd4, 8'd4);
    send_sprite(16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 15'h5555, 15'h2AAA,
                8'hAA, 8'h55, 8'hAA, 9'h155, 32'h5555_5555, 8'h55);
    send_sprite(16'h5555, 16'hAAAA, 32'h5555_5555, 15'h2AAA, 15'h5555,
                8'h55, 8'hAA, 8'h55, 9'h0AA, 32'hAAAA_AAAA, 8'hAA);
    random_sprites(40);

    // long receiver hold-off while words keep coming
    hold_go = 1'b1;
    random_sprites(30);
    drain();

    // zero sized screen, reversed depth ranges
    wr_reg(sqc_pkg::REG_VIEW_WIDTH, 32'd0);
    wr_reg(sqc_pkg::REG_VIEW_HEIGHT, 32'd0);
    wr_reg(sqc_pkg::REG_NEAR_SCREEN, 32'hFFFF_FFFF);
    wr_reg(sqc_pkg::REG_FAR_SCREEN, 32'd0);
    wr_reg(sqc_pkg::REG_NEAR_CLIP, 32'hFFFF_FFFF);
    wr_reg(sqc_pkg::REG_FAR_CLIP, 32'd0);
    wr_reg(REG_SPARE, 32'd12345);
    random_sprites(45);
    drain();

    // largest screen, full depth range, equal clip distances
    wr_reg(sqc_pkg::REG_VIEW_WIDTH, 32'h7FFF);
    wr_reg(sqc_pkg::REG_VIEW_HEIGHT, 32'hFFFF_FFFF);
    wr_reg(sqc_pkg::REG_NEAR_SCREEN, 32'd0);
    wr_reg(sqc_pkg::REG_FAR_SCREEN, 32'hFFFF_FFFF);
    wr_reg(sqc_pkg::REG_NEAR_CLIP, 32'd65536);
    wr_reg(sqc_pkg::REG_FAR_CLIP, 32'd65536);
    send_sprite(16'd10, 16'd10, 32'd65536, 15'd5, 15'd5, 8'd1, 8'd1, 8'd1, 9'd1, 32'd1, 8'd1);
    random_sprites(40);
    drain();

    // random settings
    for (int p = 0; p < 2; p++) begin
      wr_reg(sqc_pkg::REG_VIEW_WIDTH, $urandom);
      wr_reg(sqc_pkg::REG_VIEW_HEIGHT, $urandom);
      wr_reg(sqc_pkg::REG_NEAR_SCREEN, $urandom);
      wr_reg(sqc_pkg::REG_FAR_SCREEN, $urandom);
      wr_reg(sqc_pkg::REG_NEAR_CLIP, 32'($urandom_range(0, 1 << 20)));
      wr_reg(sqc_pkg::REG_FAR_CLIP, $urandom);
      random_sprites(35);
      drain();
    end

    // back to the reset values
    wr_reg(sqc_pkg::REG_VIEW_WIDTH, 32'(sqc_pkg::RST_VIEW_WIDTH));
    wr_reg(sqc_pkg::REG_VIEW_HEIGHT, 32'(sqc_pkg::RST_VIEW_HEIGHT));
    wr_reg(sqc_pkg::REG_NEAR_SCREEN, sqc_pkg::RST_NEAR_SCREEN);
    wr_reg(sqc_pkg::REG_FAR_SCREEN, sqc_pkg::RST_FAR_SCREEN);
    wr_reg(sqc_pkg::REG_NEAR_CLIP, sqc_pkg::RST_NEAR_CLIP);
    wr_reg(sqc_pkg::REG_FAR_CLIP, sqc_pkg::RST_FAR_CLIP);
    random_sprites(40);
    drain();

    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
src/sqc_pkg.sv
src/sqc_if.sv
src/sprite_quad_clip_setup_unit.sv
tb/sqc_checker.sv
tb/tb.sv
